// File: sv/atfg_pkg.sv
// Shared constants, operation codes and inter-module structs for the fade transport.
// No dependencies; every other file imports this package.
package atfg_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FADE_BITS     = 16;
  localparam int PROD_BITS     = SAMPLE_BITS + FADE_BITS;
  localparam int CNT_BITS      = $clog2(SAMPLE_BITS + 1);
  localparam int OP_BITS       = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = FADE_BITS;

  // Transport operation codes
  localparam logic [OP_BITS-1:0] OP_SAMPLE   = OP_BITS'(0);
  localparam logic [OP_BITS-1:0] OP_PLAY     = OP_BITS'(1);
  localparam logic [OP_BITS-1:0] OP_PAUSE    = OP_BITS'(2);
  localparam logic [OP_BITS-1:0] OP_STOP     = OP_BITS'(3);
  localparam logic [OP_BITS-1:0] OP_REQ_STOP = OP_BITS'(4);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_LOADED = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FADE_ENABLE   = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_FADE_LENGTH   = CFG_IDX_BITS'(2);

  localparam logic [FADE_BITS-1:0] FADE_LENGTH_RST = FADE_BITS'(256);

  // Controller to datapath commands
  typedef struct packed {
    logic                 load;
    logic                 clear;
    logic                 start;
    logic [FADE_BITS-1:0] num;
    logic [FADE_BITS-1:0] den;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy;
  } dp_sts_t;

  // Result flags handed to the output stage
  typedef struct packed {
    logic frame_end;
    logic playing;
    logic finished;
    logic rewind;
  } res_flags_t;

endpackage

// File: sv/atfg_dp.sv
// Gain datapath: sample magnitude register, one multiplier and a bit-serial divider.
// Depends on atfg_pkg; driven by atfg_ctrl through dp_cmd_t.
module atfg_dp import atfg_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output dp_sts_t                       sts,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  logic                   neg_r, neg_nxt;
  logic [SAMPLE_BITS-1:0] mag_r, mag_nxt;
  logic [FADE_BITS-1:0]   rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] low_r, low_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;

  logic [SAMPLE_BITS-1:0] in_u;
  logic [PROD_BITS-1:0]   prod;
  logic [FADE_BITS:0]     trial;
  logic [FADE_BITS:0]     diff;
  logic                   qbit;
  logic [SAMPLE_BITS-1:0] low_shift;

  assign in_u = sample_in;
  assign prod = PROD_BITS'(mag_r) * PROD_BITS'(cmd.num);

  // One restoring division step: bring down the next dividend bit, try the subtract
  assign trial     = {rem_r, low_r[SAMPLE_BITS-1]};
  assign diff      = trial - {1'b0, cmd.den};
  assign qbit      = (trial >= {1'b0, cmd.den});
  assign low_shift = {low_r[SAMPLE_BITS-2:0], qbit};

  always_comb begin
    neg_nxt = neg_r;
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    low_nxt = low_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      // Split the incoming word into sign and magnitude
      neg_nxt = in_u[SAMPLE_BITS-1];
      mag_nxt = in_u[SAMPLE_BITS-1] ? (~in_u) + SAMPLE_BITS'(1) : in_u;
    end else if (cmd.clear) begin
      neg_nxt = 1'b0;
      mag_nxt = '0;
    end else if (cmd.start) begin
      // Upper product bits are always below the divisor, so start the remainder there
      rem_nxt = prod[PROD_BITS-1:SAMPLE_BITS];
      low_nxt = prod[SAMPLE_BITS-1:0];
      cnt_nxt = CNT_BITS'(SAMPLE_BITS);
    end else if (cnt_r != '0) begin
      rem_nxt = qbit ? diff[FADE_BITS-1:0] : trial[FADE_BITS-1:0];
      low_nxt = low_shift;
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        mag_nxt = low_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
  end

  assign sts.busy   = (cnt_r != '0);
  assign sample_out = neg_r ? signed'((~mag_r) + SAMPLE_BITS'(1)) : signed'(mag_r);

endmodule

// File: sv/atfg_out.sv
// Output register stage: holds one result word until the receiver takes it.
// Depends on atfg_pkg; loaded by atfg_ctrl, sample from atfg_dp.
module atfg_out import atfg_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  res_flags_t                    flags,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_frame_end_out,
  output logic                          out_is_playing,
  output logic                          out_finished,
  output logic                          out_rewind
);

  logic                          valid_r, valid_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  res_flags_t                    flags_r, flags_nxt;

  assign free = !valid_r || out_ready;

  // Take a new word when loaded, drop the held one once accepted
  always_comb begin
    valid_nxt  = valid_r;
    sample_nxt = sample_r;
    flags_nxt  = flags_r;
    if (load) begin
      valid_nxt  = 1'b1;
      sample_nxt = sample;
      flags_nxt  = flags;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    sample_r <= sample_nxt;
    flags_r  <= flags_nxt;
  end

  assign out_valid         = valid_r;
  assign out_sample_out    = sample_r;
  assign out_frame_end_out = flags_r.frame_end;
  assign out_is_playing    = flags_r.playing;
  assign out_finished      = flags_r.finished;
  assign out_rewind        = flags_r.rewind;

endmodule

// File: sv/atfg_ctrl.sv
// Transport controller: configuration registers, play/fade state and the item sequencer.
// Depends on atfg_pkg; commands atfg_dp and loads atfg_out.
module atfg_ctrl import atfg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_BITS-1:0]       in_op,
  input  logic                     in_frame_end,
  input  logic                     in_source_has_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output dp_cmd_t                  dp_cmd,
  input  dp_sts_t                  dp_sts,
  input  logic                     out_free,
  output logic                     out_load,
  output res_flags_t               out_flags
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SC_IN,
    S_SC_OUT,
    S_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [OP_BITS-1:0]   op_r, op_nxt;
  logic                 fend_r, fend_nxt;
  logic                 has_r, has_nxt;
  logic                 src_loaded_r, src_loaded_nxt;
  logic                 fade_en_r, fade_en_nxt;
  logic [FADE_BITS-1:0] fade_len_r, fade_len_nxt;
  logic                 playing_r, playing_nxt;
  logic                 stop_pend_r, stop_pend_nxt;
  logic [FADE_BITS-1:0] fil_r, fil_nxt;
  logic [FADE_BITS-1:0] fol_r, fol_nxt;

  logic [FADE_BITS-1:0] len_eff;
  logic [FADE_BITS-1:0] n_in;
  logic [FADE_BITS-1:0] e_val;
  logic [FADE_BITS-1:0] e_dec;
  logic [FADE_BITS-1:0] n_out;
  logic                 active;

  // Gain numerators from the state as it stands before this item
  assign len_eff = (fade_len_r == '0) ? FADE_BITS'(1) : fade_len_r;
  assign n_in    = (fil_r >= len_eff) ? '0 : len_eff - fil_r;
  assign e_val   = (fol_r == '0) ? len_eff : fol_r;
  assign e_dec   = e_val - FADE_BITS'(1);
  assign n_out   = (e_dec > len_eff) ? len_eff : e_dec;
  assign active  = (op_r == OP_SAMPLE) && src_loaded_r && playing_r && has_r;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    fend_nxt       = fend_r;
    has_nxt        = has_r;
    src_loaded_nxt = src_loaded_r;
    fade_en_nxt    = fade_en_r;
    fade_len_nxt   = fade_len_r;
    playing_nxt    = playing_r;
    stop_pend_nxt  = stop_pend_r;
    fil_nxt        = fil_r;
    fol_nxt        = fol_r;
    dp_cmd         = '0;
    dp_cmd.den     = len_eff;
    dp_cmd.load    = in_valid && in_ready;
    out_load       = 1'b0;
    out_flags      = '0;

    // Register writes
    if (cfg_valid) begin
      case (cfg_index)
        REG_SOURCE_LOADED: src_loaded_nxt = cfg_data[0];
        REG_FADE_ENABLE:   fade_en_nxt    = cfg_data[0];
        REG_FADE_LENGTH:   fade_len_nxt   = cfg_data;
        default:           ;
      endcase
    end

    case (state_r)
      // Capture the word; the datapath takes the sample in the same edge
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          fend_nxt  = in_frame_end;
          has_nxt   = in_source_has_data;
          state_nxt = S_EXEC;
        end
      end
      // Pick the gain stages this word needs, or mute it
      S_EXEC: begin
        if (active) begin
          if (fil_r != '0) begin
            dp_cmd.start = 1'b1;
            dp_cmd.num   = n_in;
            state_nxt    = S_SC_IN;
          end else if (stop_pend_r) begin
            dp_cmd.start = 1'b1;
            dp_cmd.num   = n_out;
            state_nxt    = S_SC_OUT;
          end else begin
            state_nxt = S_FINISH;
          end
        end else begin
          dp_cmd.clear = 1'b1;
          state_nxt    = S_FINISH;
        end
      end
      // Fade-in scaling done: chain the fade-out one if a stop is pending
      S_SC_IN: begin
        if (!dp_sts.busy) begin
          if (stop_pend_r) begin
            dp_cmd.start = 1'b1;
            dp_cmd.num   = n_out;
            state_nxt    = S_SC_OUT;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SC_OUT: begin
        if (!dp_sts.busy) begin
          state_nxt = S_FINISH;
        end
      end
      // Commit the transport state and hand the word to the output stage
      S_FINISH: begin
        case (op_r)
          OP_SAMPLE: begin
            out_flags.frame_end = fend_r;
            if (src_loaded_r && playing_r) begin
              if (!has_r) begin
                if (!stop_pend_r) begin
                  playing_nxt        = 1'b0;
                  out_flags.finished = 1'b1;
                end
              end else if (fend_r) begin
                if (fil_r != '0) begin
                  fil_nxt = fil_r - FADE_BITS'(1);
                end
                if (stop_pend_r) begin
                  fol_nxt = e_dec;
                  if (e_dec == '0) begin
                    playing_nxt   = 1'b0;
                    stop_pend_nxt = 1'b0;
                  end
                end
              end
            end
          end
          OP_PLAY: begin
            if (src_loaded_r) begin
              fil_nxt       = fade_en_r ? fade_len_r : '0;
              stop_pend_nxt = 1'b0;
              playing_nxt   = 1'b1;
            end
          end
          OP_PAUSE: begin
            playing_nxt = 1'b0;
          end
          OP_STOP: begin
            playing_nxt      = 1'b0;
            stop_pend_nxt    = 1'b0;
            fol_nxt          = '0;
            out_flags.rewind = 1'b1;
          end
          OP_REQ_STOP: begin
            if (playing_r) begin
              stop_pend_nxt = 1'b1;
            end
          end
          default: ;
        endcase
        out_flags.playing = playing_nxt;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // Hold the state until the output register has room
          playing_nxt   = playing_r;
          stop_pend_nxt = stop_pend_r;
          fil_nxt       = fil_r;
          fol_nxt       = fol_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      src_loaded_r <= 1'b0;
      fade_en_r    <= 1'b1;
      fade_len_r   <= FADE_LENGTH_RST;
      playing_r    <= 1'b0;
      stop_pend_r  <= 1'b0;
      fil_r        <= '0;
      fol_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      src_loaded_r <= src_loaded_nxt;
      fade_en_r    <= fade_en_nxt;
      fade_len_r   <= fade_len_nxt;
      playing_r    <= playing_nxt;
      stop_pend_r  <= stop_pend_nxt;
      fil_r        <= fil_nxt;
      fol_r        <= fol_nxt;
    end
    op_r   <= op_nxt;
    fend_r <= fend_nxt;
    has_r  <= has_nxt;
  end

endmodule

// File: sv/audio_transport_fade_gain.sv
// Playback transport with linear fade-in and fade-out gain.
// Input channel (in_*): one word per command or per channel sample, in_frame_end
//   marks the last channel of a frame. Output channel (out_*): exactly one word
//   per input word, in order: gained sample, frame end copy, playing flag,
//   finished and rewind pulses.
// Configuration channel (cfg_*): index 0 source loaded, 1 fade enable,
//   2 fade length in frames; always ready, write only while the block is idle.
// Timing: one word at a time. Commands, muted samples and samples with no active
//   fade pass from S_IDLE through S_EXEC and S_FINISH into the output register,
//   and the input is ready again once the controller is back in S_IDLE. Each
//   active fade adds a pass through the shared multiply and bit-serial divide
//   unit (S_SC_IN for the fade-in, S_SC_OUT for the fade-out).
// Reset (rst_n low, synchronous): stopped, no fades pending, fade enabled,
//   fade length 256, source not loaded, output register empty.
// Stall: a finished word waits in the output register while the next word is
//   taken and worked on; that one waits in the controller until the register
//   frees.
module audio_transport_fade_gain import atfg_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_BITS-1:0]            in_op,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_frame_end,
  input  logic                          in_source_has_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_frame_end_out,
  output logic                          out_is_playing,
  output logic                          out_finished,
  output logic                          out_rewind,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  dp_cmd_t                       dp_cmd;
  dp_sts_t                       dp_sts;
  logic                          out_free;
  logic                          out_load;
  res_flags_t                    out_flags;
  logic signed [SAMPLE_BITS-1:0] dp_sample;

  atfg_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_frame_end       (in_frame_end),
    .in_source_has_data (in_source_has_data),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .dp_cmd             (dp_cmd),
    .dp_sts             (dp_sts),
    .out_free           (out_free),
    .out_load           (out_load),
    .out_flags          (out_flags)
  );

  atfg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .sample_in  (in_sample_in),
    .sts        (dp_sts),
    .sample_out (dp_sample)
  );

  atfg_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (out_load),
    .flags             (out_flags),
    .sample            (dp_sample),
    .free              (out_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_frame_end_out (out_frame_end_out),
    .out_is_playing    (out_is_playing),
    .out_finished      (out_finished),
    .out_rewind        (out_rewind)
  );

endmodule

// File: sv/atfg_checker.sv
// Port-level checks for the fade transport, attached to the top level by bind.
// Depends on atfg_pkg and audio_transport_fade_gain.
module atfg_checker import atfg_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input logic                          out_frame_end_out,
  input logic                          out_is_playing,
  input logic                          out_finished,
  input logic                          out_rewind
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out)
      && $stable(out_finished) && $stable(out_rewind) && $stable(out_is_playing))
    else $error("stalled result word changed");

  // Output register is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A stop word is muted, not playing, and no frame end
  a_rewind_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rewind |-> !out_is_playing && !out_finished
      && out_sample_out == '0 && !out_frame_end_out)
    else $error("rewind word carries playback data");

  // Source ran dry: playback has ended and the sample is muted
  a_finished_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> !out_is_playing && out_sample_out == '0)
    else $error("finished word still playing or not muted");

endmodule

bind audio_transport_fade_gain atfg_checker u_atfg_checker (.*);

// File: bench/tb.sv
// Self-checking bench for audio_transport_fade_gain: a directed table of words, then random
// phases under random register settings, checked by a behavioural predictor or typed rows.
// Depends on atfg_pkg and the audio_transport_fade_gain RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atfg_pkg::*;

  // Op codes the block must ignore
  localparam logic [OP_BITS-1:0] OP_UNKNOWN    = OP_BITS'(5);
  localparam logic [OP_BITS-1:0] OP_UNKNOWN_HI = OP_BITS'(7);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_ZERO = '0;

  localparam int PHASES      = 20;
  localparam int PHASE_WORDS = 100;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
    logic                          playing;
    logic                          finished;
    logic                          rewind;
  } fade_word_t;

  typedef struct {
    logic                 is_cfg;
    logic                 loaded;
    logic                 fade_on;
    logic [FADE_BITS-1:0] len;
    logic [OP_BITS-1:0]   op;
    logic [SAMPLE_BITS-1:0] sample;
    logic                 fend;
    logic                 has;
    logic                 typed;
    fade_word_t           want;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid           = 1'b0;
  logic                          in_ready;
  logic [OP_BITS-1:0]            in_op              = OP_SAMPLE;
  logic signed [SAMPLE_BITS-1:0] in_sample_in       = '0;
  logic                          in_frame_end       = 1'b0;
  logic                          in_source_has_data = 1'b0;
  logic                          out_valid;
  logic                          out_ready          = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic                          out_frame_end_out;
  logic                          out_is_playing;
  logic                          out_finished;
  logic                          out_rewind;
  logic                          cfg_valid          = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index          = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data           = '0;

  // Predictor copy of registers and transport state
  logic                 src_loaded;
  logic                 fade_on;
  logic [FADE_BITS-1:0] fade_len;
  logic                 play_st;
  logic                 stop_pend;
  logic [FADE_BITS-1:0] fade_in_cnt;
  logic [FADE_BITS-1:0] fade_out_cnt;

  fade_word_t pending_words[$];
  plan_row_t  plan[$];

  int  errors       = 0;
  int  words_sent   = 0;
  int  words_seen   = 0;
  int  settings     = 0;
  int  holds_done   = 0;
  int  directed_len = 0;
  bit  no_gaps      = 1'b0;
  bit  hold_off_req = 1'b0;

  audio_transport_fade_gain DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_sample_in      (in_sample_in),
    .in_frame_end      (in_frame_end),
    .in_source_has_data(in_source_has_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_frame_end_out (out_frame_end_out),
    .out_is_playing    (out_is_playing),
    .out_finished      (out_finished),
    .out_rewind        (out_rewind),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // Work out the result word for one accepted input word and advance the state
  function automatic fade_word_t predict_fade(input logic [OP_BITS-1:0] op,
                                              input logic signed [SAMPLE_BITS-1:0] smp,
                                              input logic fend, input logic has);
    fade_word_t  w;
    int unsigned len;
    int unsigned n;
    int unsigned e;
    longint      s;
    w   = '0;
    s   = 0;
    len = (fade_len == 0) ? 1 : 32'(fade_len);
    case (op)
      OP_SAMPLE: begin
        w.frame_end = fend;
        if (src_loaded && play_st) begin
          if (!has) begin
            // source dry: end playback unless a fade-out is stalled on it
            if (!stop_pend) begin
              play_st    = 1'b0;
              w.finished = 1'b1;
            end
          end else begin
            s = longint'(smp);
            if (fade_in_cnt > 0) begin
              n = (32'(fade_in_cnt) >= len) ? 0 : len - 32'(fade_in_cnt);
              s = (s * longint'(n)) / longint'(len);
              if (fend) fade_in_cnt--;
            end
            if (stop_pend) begin
              e = (fade_out_cnt == 0) ? len : 32'(fade_out_cnt);
              n = e - 1;
              if (n > len) n = len;
              s = (s * longint'(n)) / longint'(len);
              if (fend) begin
                fade_out_cnt = FADE_BITS'(e - 1);
                if (fade_out_cnt == 0) begin
                  play_st   = 1'b0;
                  stop_pend = 1'b0;
                end
              end
            end
          end
        end
      end
      OP_PLAY: begin
        if (src_loaded) begin
          fade_in_cnt = fade_on ? fade_len : '0;
          stop_pend   = 1'b0;
          play_st     = 1'b1;
        end
      end
      OP_PAUSE: play_st = 1'b0;
      OP_STOP: begin
        play_st      = 1'b0;
        stop_pend    = 1'b0;
        fade_out_cnt = '0;
        w.rewind     = 1'b1;
      end
      OP_REQ_STOP: begin
        if (play_st) stop_pend = 1'b1;
      end
      default: ;
    endcase
    w.sample  = s[SAMPLE_BITS-1:0];
    w.playing = play_st;
    return w;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic void push_cfg(input logic loaded, input logic en,
                                   input logic [FADE_BITS-1:0] len);
    plan_row_t r;
    r         = '{default: '0};
    r.is_cfg  = 1'b1;
    r.loaded  = loaded;
    r.fade_on = en;
    r.len     = len;
    plan.push_back(r);
  endfunction

  function automatic void push_word(input logic [OP_BITS-1:0] op,
                                    input logic [SAMPLE_BITS-1:0] smp,
                                    input logic fend, input logic has,
                                    input logic typed, input fade_word_t want);
    plan_row_t r;
    r        = '{default: '0};
    r.op     = op;
    r.sample = smp;
    r.fend   = fend;
    r.has    = has;
    r.typed  = typed;
    r.want   = want;
    plan.push_back(r);
  endfunction

  // Offer one word after a random gap; predict its result once it is taken
  task automatic send_word(input logic [OP_BITS-1:0] op, input logic [SAMPLE_BITS-1:0] smp,
                           input logic fend, input logic has,
                           input logic typed, input fade_word_t want);
    int         gap;
    fade_word_t pred;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_op              <= op;
    in_sample_in       <= smp;
    in_frame_end       <= fend;
    in_source_has_data <= has;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_fade(op, smp, fend, has);
    pending_words.push_back(typed ? want : pred);
    words_sent++;
  endtask

  // Drop valid, wait for every expected word, then let the block settle
  task automatic drain_words(input int settle);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write all three registers back to back while the block is idle
  task automatic load_regs(input logic loaded, input logic en, input logic [FADE_BITS-1:0] len);
    logic [CFG_IDX_BITS-1:0]  idx [3];
    logic [CFG_DATA_BITS-1:0] val [3];
    int i;
    idx[0] = REG_SOURCE_LOADED;
    idx[1] = REG_FADE_ENABLE;
    idx[2] = REG_FADE_LENGTH;
    val[0] = CFG_DATA_BITS'(loaded);
    val[1] = CFG_DATA_BITS'(en);
    val[2] = len;
    drain_words(8);
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    src_loaded = loaded;
    fade_on    = en;
    fade_len   = len;
    settings++;
  endtask

  // Compare one accepted result word with the oldest expectation
  task automatic check_word();
    fade_word_t exp_w;
    words_seen++;
    if (pending_words.size() == 0) begin
      $error("result word with nothing expected: sample_out %0d", out_sample_out);
      errors++;
    end else begin
      exp_w = pending_words.pop_front();
      if (out_sample_out !== exp_w.sample) begin
        $error("sample_out: expected %0d, got %0d", exp_w.sample, out_sample_out);
        errors++;
      end
      if (out_frame_end_out !== exp_w.frame_end) begin
        $error("frame_end_out: expected %0b, got %0b", exp_w.frame_end, out_frame_end_out);
        errors++;
      end
      if (out_is_playing !== exp_w.playing) begin
        $error("is_playing: expected %0b, got %0b", exp_w.playing, out_is_playing);
        errors++;
      end
      if (out_finished !== exp_w.finished) begin
        $error("finished: expected %0b, got %0b", exp_w.finished, out_finished);
        errors++;
      end
      if (out_rewind !== exp_w.rewind) begin
        $error("rewind: expected %0b, got %0b", exp_w.rewind, out_rewind);
        errors++;
      end
    end
  endtask

  // Receiver: random stalls per word, a long hold-off when asked
  initial begin : receiver
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall        = HOLD_CYCLES;
        holds_done++;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 4);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_word();
    end
  end

  initial begin : stimulus
    int         phase;
    int         count;
    int         chans;
    int         c;
    int         pick;
    bit         held;
    logic       loaded;
    logic       en;
    logic [FADE_BITS-1:0] len;
    fade_word_t none;

    none         = '0;
    src_loaded   = 1'b0;
    fade_on      = 1'b1;
    fade_len     = FADE_LENGTH_RST;
    play_st      = 1'b0;
    stop_pend    = 1'b0;
    fade_in_cnt  = '0;
    fade_out_cnt = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // After reset: nothing loaded, so everything is muted or ignored
    push_word(OP_SAMPLE, S_MAX, 1'b1, 1'b1, 1'b1, fade_word_t'{S_ZERO, 1'b1, 1'b0, 1'b0, 1'b0});
    push_word(OP_PLAY, S_ZERO, 1'b0, 1'b0, 1'b1, none);
    push_word(OP_REQ_STOP, S_ZERO, 1'b0, 1'b0, 1'b1, none);
    push_word(OP_STOP, S_ZERO, 1'b0, 1'b0, 1'b1, fade_word_t'{S_ZERO, 1'b0, 1'b0, 1'b0, 1'b1});
    push_word(OP_UNKNOWN, S_MAX, 1'b1, 1'b1, 1'b1, none);
    // Loaded, no fades: samples pass at unity gain, then the source runs dry
    push_cfg(1'b1, 1'b0, FADE_LENGTH_RST);
    push_word(OP_PLAY, S_ZERO, 1'b0, 1'b0, 1'b1, fade_word_t'{S_ZERO, 1'b0, 1'b1, 1'b0, 1'b0});
    push_word(OP_SAMPLE, S_MAX, 1'b0, 1'b1, 1'b1, fade_word_t'{S_MAX, 1'b0, 1'b1, 1'b0, 1'b0});
    push_word(OP_SAMPLE, S_MIN, 1'b1, 1'b1, 1'b1, fade_word_t'{S_MIN, 1'b1, 1'b1, 1'b0, 1'b0});
    push_word(OP_UNKNOWN_HI, S_MIN, 1'b1, 1'b1, 1'b1,
              fade_word_t'{S_ZERO, 1'b0, 1'b1, 1'b0, 1'b0});
    push_word(OP_SAMPLE, S_MAX, 1'b1, 1'b0, 1'b1, fade_word_t'{S_ZERO, 1'b1, 1'b0, 1'b1, 1'b0});
    // Short fades: fade-in from silence, stalled fade-out, play over a half-done fade-out
    push_cfg(1'b1, 1'b1, FADE_BITS'(4));
    push_word(OP_PLAY, S_ZERO, 1'b0, 1'b0, 1'b1, fade_word_t'{S_ZERO, 1'b0, 1'b1, 1'b0, 1'b0});
    push_word(OP_SAMPLE, S_MAX, 1'b1, 1'b1, 1'b1, fade_word_t'{S_ZERO, 1'b1, 1'b1, 1'b0, 1'b0});
    push_word(OP_SAMPLE, S_MIN, 1'b0, 1'b1, 1'b0, none);
    push_word(OP_REQ_STOP, S_ZERO, 1'b0, 1'b0, 1'b0, none);
    push_word(OP_SAMPLE, S_MAX, 1'b1, 1'b0, 1'b0, none);
    push_word(OP_SAMPLE, S_MAX, 1'b1, 1'b1, 1'b0, none);
    push_word(OP_PLAY, S_ZERO, 1'b0, 1'b0, 1'b1, fade_word_t'{S_ZERO, 1'b0, 1'b1, 1'b0, 1'b0});
    push_word(OP_REQ_STOP, S_ZERO, 1'b0, 1'b0, 1'b0, none);
    push_word(OP_SAMPLE, S_MIN, 1'b1, 1'b1, 1'b0, none);
    push_word(OP_SAMPLE, S_MAX, 1'b1, 1'b1, 1'b0, none);
    push_word(OP_SAMPLE, S_MAX, 1'b1, 1'b1, 1'b0, none);
    push_word(OP_PAUSE, S_ZERO, 1'b0, 1'b0, 1'b1, none);
    // Zero fade length behaves as one frame
    push_cfg(1'b1, 1'b1, FADE_BITS'(0));
    push_word(OP_PLAY, S_ZERO, 1'b0, 1'b0, 1'b0, none);
    push_word(OP_REQ_STOP, S_ZERO, 1'b0, 1'b0, 1'b0, none);
    push_word(OP_SAMPLE, S_MIN, 1'b1, 1'b1, 1'b0, none);
    // Longest fade length
    push_cfg(1'b1, 1'b1, {FADE_BITS{1'b1}});
    push_word(OP_PLAY, S_ZERO, 1'b0, 1'b0, 1'b0, none);
    push_word(OP_SAMPLE, S_MIN, 1'b1, 1'b1, 1'b0, none);
    push_word(OP_SAMPLE, S_MIN, 1'b1, 1'b1, 1'b0, none);
    // Source unloaded while playing: muted, state held
    push_cfg(1'b0, 1'b1, {FADE_BITS{1'b1}});
    push_word(OP_SAMPLE, S_MAX, 1'b1, 1'b0, 1'b1, fade_word_t'{S_ZERO, 1'b1, 1'b1, 1'b0, 1'b0});
    push_word(OP_STOP, S_ZERO, 1'b0, 1'b0, 1'b1, fade_word_t'{S_ZERO, 1'b0, 1'b0, 1'b0, 1'b1});

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        load_regs(plan[i].loaded, plan[i].fade_on, plan[i].len);
      end else begin
        send_word(plan[i].op, plan[i].sample, plan[i].fend, plan[i].has,
                  plan[i].typed, plan[i].want);
      end
    end
    directed_len = words_sent;

    // Random phases: mostly whole frames while playing, some commands and noise
    for (phase = 0; phase < PHASES; phase++) begin
      loaded = ($urandom_range(0, 9) != 0);
      en     = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = {FADE_BITS{1'b1}};
        2:       len = FADE_BITS'($urandom_range(9, 300));
        default: len = FADE_BITS'($urandom_range(1, 8));
      endcase
      load_regs(loaded, en, len);
      no_gaps = (phase % 5 == 4);
      held    = 1'b0;
      count   = 0;
      while (count < PHASE_WORDS) begin
        // ask for one long receiver hold-off mid-phase while words keep coming
        if (!held && count >= PHASE_WORDS / 2 && (phase == 3 || phase == 12)) begin
          hold_off_req = 1'b1;
          held         = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          chans = $urandom_range(1, 4);
          for (c = 0; c < chans; c++) begin
            send_word(OP_SAMPLE, rand_sample(), (c == chans - 1),
                      ($urandom_range(0, 31) != 0), 1'b0, none);
          end
          count += chans;
        end else begin
          if (pick < 78) begin
            send_word(OP_PLAY, rand_sample(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, none);
          end else if (pick < 84) begin
            send_word(OP_REQ_STOP, rand_sample(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, none);
          end else if (pick < 88) begin
            send_word(OP_PAUSE, rand_sample(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, none);
          end else if (pick < 92) begin
            send_word(OP_STOP, rand_sample(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, none);
          end else if (pick < 95) begin
            send_word(OP_BITS'($urandom_range(OP_UNKNOWN, OP_UNKNOWN_HI)), rand_sample(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, none);
          end else begin
            send_word(OP_SAMPLE, rand_sample(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, none);
          end
          count++;
        end
      end
    end

    drain_words(60);
    $display("Run covered %0d words (%0d from the directed table) over %0d register settings,",
             words_sent, directed_len, settings);
    $display("with %0d long receiver hold-offs and %0d result words checked.",
             holds_done, words_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
sv/atfg_pkg.sv
sv/atfg_dp.sv
sv/atfg_out.sv
sv/atfg_ctrl.sv
sv/audio_transport_fade_gain.sv
sv/atfg_checker.sv
bench/tb.sv
